/* src/r2fft_pkg.sv */
// shared constants, types and twiddle table for the radix-2 fft block
package r2fft_pkg;

  localparam int MaxPoints = 64;
  localparam int SampleW = 16;
  localparam int PointW = 23;
  localparam int TwW = 17;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 3;

  localparam logic [CfgIdxW-1:0] RegLog2Size = 1'd0;
  localparam logic [CfgIdxW-1:0] RegInverse = 1'd1;

  localparam logic signed [PointW-1:0] PointMax = 23'sh3fffff;
  localparam logic signed [PointW-1:0] PointMin = -23'sh400000;

  typedef logic signed [PointW-1:0] point_t;
  typedef logic signed [TwW-1:0] tw_t;

  function automatic logic [16:0] quarter_cos(input logic [4:0] m);
    logic [16:0] v;
    case (m)
      5'd0: v = 17'd32768;
      5'd1: v = 17'd32610;
      5'd2: v = 17'd32138;
      5'd3: v = 17'd31357;
      5'd4: v = 17'd30274;
      5'd5: v = 17'd28899;
      5'd6: v = 17'd27246;
      5'd7: v = 17'd25330;
      5'd8: v = 17'd23170;
      5'd9: v = 17'd20788;
      5'd10: v = 17'd18205;
      5'd11: v = 17'd15447;
      5'd12: v = 17'd12540;
      5'd13: v = 17'd9512;
      5'd14: v = 17'd6393;
      5'd15: v = 17'd3212;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // twiddle exp(-2 pi i m / 64) for m in 0..31
  function automatic void twiddle(input logic [4:0] m, output tw_t wr, output tw_t wi);
    logic [16:0] c;
    logic [16:0] s;
    if (m <= 5'd16) begin
      c = quarter_cos(m);
      s = quarter_cos(5'(5'd16 - m));
      wr = tw_t'(c);
    end else begin
      c = quarter_cos(5'(6'd32 - {1'b0, m}));
      s = quarter_cos(5'(m - 5'd16));
      wr = -tw_t'(c);
    end
    wi = -tw_t'(s);
  endfunction

  function automatic point_t sat(input logic signed [PointW+1:0] v);
    point_t r;
    if (v > (PointW+2)'(PointMax)) r = PointMax;
    else if (v < (PointW+2)'(PointMin)) r = PointMin;
    else r = v[PointW-1:0];
    return r;
  endfunction

endpackage

/* src/r2fft_bfly.sv */
// pipelined complex butterfly unit with rounded twiddle products
module r2fft_bfly (
  input  logic                   clk,
  input  logic                   in_valid,
  input  r2fft_pkg::point_t      ar,
  input  r2fft_pkg::point_t      ai,
  input  r2fft_pkg::point_t      br,
  input  r2fft_pkg::point_t      bi,
  input  r2fft_pkg::tw_t         wr,
  input  r2fft_pkg::tw_t         wi,
  output logic                   out_valid,
  output r2fft_pkg::point_t      pr,
  output r2fft_pkg::point_t      pi,
  output r2fft_pkg::point_t      qr,
  output r2fft_pkg::point_t      qi
);
  logic signed [39:0] m_rr, m_ii, m_ir, m_ri;
  r2fft_pkg::point_t  ar1, ai1;
  logic               v1;
  logic signed [41:0] sr, si;
  logic signed [26:0] tr, ti;

  always_ff @(posedge clk) begin
    m_rr <= br * wr;
    m_ii <= bi * wi;
    m_ir <= bi * wr;
    m_ri <= br * wi;
    ar1 <= ar;
    ai1 <= ai;
  end

  always_comb begin
    sr = 42'(m_rr) - 42'(m_ii) + 42'sd16384;
    si = 42'(m_ir) + 42'(m_ri) + 42'sd16384;
    tr = 27'(sr >>> 15);
    ti = 27'(si >>> 15);
  end

  always_ff @(posedge clk) begin
    pr <= r2fft_pkg::sat(25'(27'(ar1) + tr));
    pi <= r2fft_pkg::sat(25'(27'(ai1) + ti));
    qr <= r2fft_pkg::sat(25'(27'(ar1) - tr));
    qi <= r2fft_pkg::sat(25'(27'(ai1) - ti));
  end

  always_ff @(posedge clk) begin
    v1 <= in_valid;
    out_valid <= v1;
  end
endmodule

/* src/radix2_fft_with_inverse.sv */
// top level of the radix-2 decimation-in-time fft with inverse mode
// usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 log2_size,
//   index 1 inverse_mode; any listed write discards a partly loaded frame.
//   in channel: one complex sample per transaction; ready while loading.
//   after the last sample of a frame (2^k samples) the block stops taking
//   samples, runs k stages of n/2 butterflies on one shared butterfly unit,
//   one butterfly at a time in four steps (read, multiply, add, write), then
//   emits n bins in order on the out channel, final_bin on the last.
//   output is held in a register; a receiver stall holds it and the
//   sequencer waits. log2_size 0 passes each sample through as a final bin.
//   reset (rst, synchronous) restores log2_size 6, forward mode and an
//   empty frame; the point store holds no reset value.
module radix2_fft_with_inverse #(
  parameter int MAX_POINTS = r2fft_pkg::MaxPoints
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [r2fft_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [r2fft_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [r2fft_pkg::SampleW-1:0] sample_re,
  input  logic signed [r2fft_pkg::SampleW-1:0] sample_im,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [22:0]              bin_re,
  output logic signed [22:0]              bin_im,
  output logic                            final_bin
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int KMAX = AW;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_ADD  = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [2:0] log2_size;
  logic inverse_mode;
  logic [AW-1:0] cnt;
  logic [2:0] k;
  logic [2:0] stage;
  logic [AW-1:0] bidx;
  logic [AW-1:0] p_addr, q_addr;
  logic [4:0] tw_m;
  r2fft_pkg::point_t mem_re [MAX_POINTS];
  r2fft_pkg::point_t mem_im [MAX_POINTS];
  r2fft_pkg::point_t ar, ai, br, bi;
  r2fft_pkg::tw_t wr, wi;
  r2fft_pkg::tw_t wr_next, wi_next;
  logic bv;
  r2fft_pkg::point_t pr, pi, qr, qi;
  logic [AW:0] n;
  logic [AW-1:0] nm1;
  logic [AW-1:0] half;
  logic [AW-1:0] jj, grp;
  logic [AW-1:0] ld_addr;
  logic [AW-1:0] rd_addr;
  logic cfg_hit, in_hit, out_hit;
  logic emit;
  logic out_pend;
  logic [AW-1:0] ocnt;
  r2fft_pkg::point_t or_re, or_im;
  logic signed [23:0] h_re, h_im;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid &&
    (cfg_index == r2fft_pkg::RegLog2Size || cfg_index == r2fft_pkg::RegInverse);

  always_comb begin
    if (log2_size > 3'(KMAX)) k = 3'(KMAX);
    else k = log2_size;
  end
  assign n = (AW+1)'(1) << k;
  assign nm1 = AW'(n - 1'b1);

  function automatic logic [AW-1:0] brev(input logic [AW-1:0] v, input logic [2:0] bits);
    logic [AW-1:0] r;
    r = '0;
    for (int b = 0; b < AW; b++) begin
      if (3'(b) < bits) r[3'(bits - 3'(b) - 3'd1)] = v[b];
    end
    return r;
  endfunction

  assign in_ready = (state == S_LOAD) && !out_pend;
  assign in_hit = in_valid && in_ready;
  assign ld_addr = brev(cnt, k);

  // butterfly addressing within stage s: half = 2^(s-1)
  always_comb begin
    half = AW'(1) << (stage - 3'd1);
    jj = bidx & AW'(half - 1'b1);
    grp = (bidx & ~AW'(half - 1'b1)) << 1;
    p_addr = grp | jj;
    q_addr = p_addr | half;
    tw_m = 5'(jj << (3'(KMAX) - stage)) << (3'd6 - 3'(KMAX));
  end

  assign out_hit = out_valid && out_ready;
  assign emit = (state == S_OUT) && out_pend && (!out_valid || out_hit);
  assign rd_addr = (state == S_RD) ? q_addr : ocnt;

  always_ff @(posedge clk) begin
    if (in_hit) begin
      mem_re[ld_addr] <= r2fft_pkg::point_t'(sample_re);
      mem_im[ld_addr] <= inverse_mode ? -r2fft_pkg::point_t'(sample_im)
                                      : r2fft_pkg::point_t'(sample_im);
    end else if (bv) begin
      mem_re[p_addr] <= pr;
      mem_im[p_addr] <= pi;
      mem_re[q_addr] <= qr;
      mem_im[q_addr] <= qi;
    end
    br <= mem_re[rd_addr];
    bi <= mem_im[rd_addr];
    ar <= mem_re[p_addr];
    ai <= mem_im[p_addr];
  end

  always_comb begin
    r2fft_pkg::twiddle(tw_m, wr_next, wi_next);
  end

  always_ff @(posedge clk) begin
    wr <= wr_next;
    wi <= wi_next;
  end

  r2fft_bfly u_bfly (
    .clk(clk), .in_valid(state == S_MUL),
    .ar(ar), .ai(ai), .br(br), .bi(bi), .wr(wr), .wi(wi),
    .out_valid(bv), .pr(pr), .pi(pi), .qr(qr), .qi(qi)
  );

  always_comb begin
    h_re = 24'(br);
    h_im = -24'(bi);
    if (inverse_mode && k != 3'd0) begin
      h_re = (h_re + (24'sd1 <<< (k - 3'd1))) >>> k;
      h_im = (h_im + (24'sd1 <<< (k - 3'd1))) >>> k;
    end
    or_re = inverse_mode ? r2fft_pkg::sat(25'(h_re)) : br;
    or_im = inverse_mode ? r2fft_pkg::sat(25'(h_im)) : bi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      log2_size <= 3'd6;
      inverse_mode <= 1'b0;
      cnt <= '0;
      stage <= 3'd1;
      bidx <= '0;
      ocnt <= '0;
      out_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_hit) out_valid <= 1'b0;
      if (cfg_valid && cfg_index == r2fft_pkg::RegLog2Size) log2_size <= cfg_data;
      if (cfg_valid && cfg_index == r2fft_pkg::RegInverse) inverse_mode <= cfg_data[0];
      case (state)
        S_LOAD: begin
          if (cfg_hit) begin
            cnt <= '0;
          end else if (in_hit) begin
            if (cnt == nm1) begin
              cnt <= '0;
              stage <= 3'd1;
              bidx <= '0;
              ocnt <= '0;
              state <= (k == 3'd0) ? S_OUT : S_RD;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_WR;
        S_WR: begin
          if (bidx == AW'((n >> 1) - 1'b1)) begin
            bidx <= '0;
            if (stage == k) begin
              state <= S_OUT;
            end else begin
              stage <= stage + 3'd1;
              state <= S_RD;
            end
          end else begin
            bidx <= bidx + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (emit) begin
            bin_re <= or_re;
            bin_im <= or_im;
            final_bin <= (ocnt == nm1);
            out_pend <= 1'b0;
            if (ocnt == nm1) begin
              ocnt <= '0;
              state <= S_LOAD;
            end else begin
              ocnt <= ocnt + 1'b1;
            end
          end else if (!out_pend) begin
            out_pend <= 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
